// ===== hdl/slt_pkg.sv =====
package slt_pkg;

   // field widths fixed by the item format
   localparam int REQ_W   = 2;
   localparam int VALUE_W = 32;
   localparam int SLOT_W  = 6;
   localparam int STAT_W  = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_SEARCH = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_MEDIAN = 2'd3
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

endpackage

// ===== hdl/slt_if.sv =====
// request channel: one operation per item
interface slt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [slt_pkg::REQ_W-1:0]            req_type;
   logic signed [slt_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

// response channel: one result per request
interface slt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [slt_pkg::STAT_W-1:0]           status;
   logic [slt_pkg::SLOT_W-1:0]           slot;
   logic signed [slt_pkg::VALUE_W-1:0]   result_value;
   logic [slt_pkg::SLOT_W-1:0]           live_count;

   modport source (output valid, output status, output slot, output result_value,
                   output live_count, input ready);
   modport sink   (input valid, input status, input slot, input result_value,
                   input live_count, output ready);
endinterface

// ===== hdl/slt_ram.sv =====
module slt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/sorted_linked_list_table_core.sv =====
// channel    dir   handshake              payload
// req_chan   in    valid/ready            req_type, value
// rsp_chan   out   valid/ready            status, slot, result_value, live_count
//
// One request at a time, taken only in idle. A walk visits at most SLOTS-1
// elements, then loads the output register; an insert writes the new element
// in S_INSERT and then relinks a predecessor in S_LINK when there is one.
// Answers that need no walk go from idle straight to S_DONE. The walk is
// paced by the registered read of the value and link memories.
// Reset empties the list at once: the head link is a register. A result left
// in the output register holds the next result back, not the next item.
module sorted_linked_list_table_core #(
   parameter int SLOTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   slt_req_if.sink    req_chan,
   slt_rsp_if.source  rsp_chan
);

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_INSERT,
      S_LINK,
      S_DONE
   } state_type;

   state_type                         state_ff, state_in;
   slt_pkg::req_kind_type             op_ff, op_in;
   logic signed [slt_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [IW-1:0]                     cur_ff, cur_in;
   logic [IW-1:0]                     prev_ff, prev_in;
   logic [IW-1:0]                     cnt_ff, cnt_in;
   logic [IW-1:0]                     mid_ff, mid_in;
   logic [IW-1:0]                     head_ff, head_in;
   logic [IW-1:0]                     used_ff, used_in;
   logic [IW-1:0]                     live_ff, live_in;
   slt_pkg::status_type               res_status_ff, res_status_in;
   logic [IW-1:0]                     res_slot_ff, res_slot_in;
   logic signed [slt_pkg::VALUE_W-1:0] res_value_ff, res_value_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   slt_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [slt_pkg::SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic signed [slt_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [slt_pkg::SLOT_W-1:0]        rsp_live_ff, rsp_live_in;

   // memory ports
   logic [IW-1:0]                     rd_addr;
   logic                              val_we;
   logic [IW-1:0]                     val_waddr;
   logic [slt_pkg::VALUE_W-1:0]       val_wdata;
   logic [slt_pkg::VALUE_W-1:0]       val_rdata;
   logic                              nxt_we;
   logic [IW-1:0]                     nxt_waddr;
   logic [IW-1:0]                     nxt_wdata;
   logic [IW-1:0]                     nxt_rdata;

   logic signed [slt_pkg::VALUE_W-1:0] rd_val;
   logic [IW:0]                       live_plus;
   logic [IW-1:0]                     new_slot;
   logic [slt_pkg::SLOT_W+IW-1:0]     slot_wide;
   logic [slt_pkg::SLOT_W+IW-1:0]     live_wide;
   slt_pkg::req_kind_type             req_kind;

   slt_ram #(.WIDTH(slt_pkg::VALUE_W), .DEPTH(SLOTS)) u_value_store (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   slt_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_next_store (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_waddr),
      .wr_data (nxt_wdata),
      .rd_addr (rd_addr),
      .rd_data (nxt_rdata)
   );

   assign rd_val    = $signed(val_rdata);
   assign live_plus = {1'b0, live_ff} + {{IW{1'b0}}, 1'b1};
   assign new_slot  = used_ff + IW'(1);
   assign req_kind  = slt_pkg::req_kind_type'(req_chan.req_type);
   assign slot_wide = {{slt_pkg::SLOT_W{1'b0}}, res_slot_ff};
   assign live_wide = {{slt_pkg::SLOT_W{1'b0}}, live_ff};

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.slot         = rsp_slot_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.live_count   = rsp_live_ff;

   // sequence one request: walk, update links, stage the result
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      cnt_in        = cnt_ff;
      mid_in        = mid_ff;
      head_in       = head_ff;
      used_in       = used_ff;
      live_in       = live_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_live_in   = rsp_live_ff;
      rd_addr       = cur_ff;
      val_we        = 1'b0;
      val_waddr     = new_slot;
      val_wdata     = val_ff;
      nxt_we        = 1'b0;
      nxt_waddr     = prev_ff;
      nxt_wdata     = cur_ff;

      // drop the output item once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            rd_addr = head_ff;
            if (req_chan.valid) begin
               op_in         = req_kind;
               val_in        = req_chan.value;
               cur_in        = head_ff;
               prev_in       = '0;
               cnt_in        = IW'(1);
               mid_in        = live_plus[IW:1];
               res_status_in = slt_pkg::ST_OK;
               res_slot_in   = '0;
               res_value_in  = '0;
               case (req_kind)
                  slt_pkg::REQ_INSERT: begin
                     if (used_ff >= LAST_SLOT) begin
                        res_status_in = slt_pkg::ST_FULL;
                        state_in      = S_DONE;
                     end else if (head_ff == '0) begin
                        state_in = S_INSERT;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  slt_pkg::REQ_MEDIAN: begin
                     if (head_ff == '0 || live_ff == '0) begin
                        res_status_in = slt_pkg::ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     if (head_ff == '0) begin
                        res_status_in = slt_pkg::ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
               endcase
            end
         end

         // read data of cur_ff is valid; decide, or advance one link
         S_WALK: begin
            case (op_ff)
               slt_pkg::REQ_INSERT: begin
                  if (val_ff > rd_val) begin
                     prev_in = cur_ff;
                     cur_in  = nxt_rdata;
                     rd_addr = nxt_rdata;
                     if (nxt_rdata == '0) begin
                        state_in = S_INSERT;
                     end
                  end else begin
                     state_in = S_INSERT;
                  end
               end
               slt_pkg::REQ_MEDIAN: begin
                  if (cnt_ff == mid_ff || nxt_rdata == '0) begin
                     res_slot_in  = cur_ff;
                     res_value_in = rd_val;
                     state_in     = S_DONE;
                  end else begin
                     cnt_in  = cnt_ff + IW'(1);
                     cur_in  = nxt_rdata;
                     rd_addr = nxt_rdata;
                  end
               end
               default: begin
                  if (rd_val == val_ff) begin
                     res_slot_in  = cur_ff;
                     res_value_in = val_ff;
                     state_in     = S_DONE;
                     if (op_ff == slt_pkg::REQ_DELETE) begin
                        // unlink the match
                        live_in = live_ff - IW'(1);
                        if (prev_ff == '0) begin
                           head_in = nxt_rdata;
                        end else begin
                           nxt_we    = 1'b1;
                           nxt_waddr = prev_ff;
                           nxt_wdata = nxt_rdata;
                        end
                     end
                  end else if (nxt_rdata == '0) begin
                     res_status_in = slt_pkg::ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     prev_in = cur_ff;
                     cur_in  = nxt_rdata;
                     rd_addr = nxt_rdata;
                  end
               end
            endcase
         end

         // write the new element, pointing at the first not-smaller one
         S_INSERT: begin
            val_we       = 1'b1;
            val_waddr    = new_slot;
            val_wdata    = val_ff;
            nxt_we       = 1'b1;
            nxt_waddr    = new_slot;
            nxt_wdata    = cur_ff;
            used_in      = new_slot;
            live_in      = live_ff + IW'(1);
            res_slot_in  = new_slot;
            res_value_in = val_ff;
            if (prev_ff == '0) begin
               head_in  = new_slot;
               state_in = S_DONE;
            end else begin
               state_in = S_LINK;
            end
         end

         // point the predecessor at the new element
         S_LINK: begin
            nxt_we    = 1'b1;
            nxt_waddr = prev_ff;
            nxt_wdata = used_ff;
            state_in  = S_DONE;
         end

         // hold the result until the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot_wide[slt_pkg::SLOT_W-1:0];
               rsp_value_in  = res_value_ff;
               rsp_live_in   = live_wide[slt_pkg::SLOT_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         used_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      cnt_ff        <= cnt_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_live_ff   <= rsp_live_in;
   end

endmodule

// ===== bench/sorted_linked_list_table_core_tb.sv =====
`timescale 1ns / 1ps

module sorted_linked_list_table_core_tb;

   localparam int SLOTS            = 64;
   localparam int STALL_LIMIT      = 4000;
   localparam int DRAIN_CYCLES     = 80;
   localparam int RANDOM_PER_PHASE = 460;

   typedef struct packed {
      slt_pkg::req_kind_type              kind;
      logic signed [slt_pkg::VALUE_W-1:0] operand;
   } table_req_type;

   typedef struct packed {
      slt_pkg::status_type                status;
      logic [slt_pkg::SLOT_W-1:0]         slot;
      logic signed [slt_pkg::VALUE_W-1:0] value;
      logic [slt_pkg::SLOT_W-1:0]         count;
   } table_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slt_req_if req_chan();
   slt_rsp_if rsp_chan();

   sorted_linked_list_table_core #(.SLOTS(SLOTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the list
   logic signed [slt_pkg::VALUE_W-1:0] key_mem [SLOTS];
   int                                 link_mem [SLOTS];
   int                                 slots_taken;
   int                                 live_total;

   table_req_type                      req_backlog [$];
   table_rsp_type                      rsp_due [$];
   logic signed [slt_pkg::VALUE_W-1:0] inserted_values [$];
   table_req_type                      next_req;
   table_req_type                      seen_req;
   table_rsp_type                      want;
   int                                 inserts_issued;
   int                                 send_idle_pct;
   int                                 recv_idle_pct;
   bit                                 req_taken;
   bit                                 rsp_taken;
   int                                 stall_cycles;
   int                                 fail_count;

   initial begin
      forever #4 clock = ~clock;
   end

   // walk the shadow list and apply one request, returning its result
   function automatic table_rsp_type table_apply(table_req_type r);
      table_rsp_type res;
      int            prev;
      int            cur;
      int            steps;
      int            target;
      int            nx;
      res.status = slt_pkg::ST_OK;
      res.slot   = '0;
      res.value  = '0;
      prev       = 0;
      cur        = link_mem[0];
      steps      = 0;
      case (r.kind)
         slt_pkg::REQ_INSERT: begin
            if (slots_taken >= SLOTS - 1) begin
               res.status = slt_pkg::ST_FULL;
            end else begin
               // stop at the first element larger than or equal to the new one
               while (cur != 0 && steps < SLOTS && r.operand > key_mem[cur]) begin
                  prev = cur;
                  cur  = link_mem[cur];
                  steps++;
               end
               slots_taken++;
               key_mem[slots_taken]  = r.operand;
               link_mem[prev]        = slots_taken;
               link_mem[slots_taken] = cur;
               live_total++;
               res.slot  = slt_pkg::SLOT_W'(slots_taken);
               res.value = r.operand;
            end
         end
         slt_pkg::REQ_SEARCH, slt_pkg::REQ_DELETE: begin
            while (cur != 0 && steps < SLOTS && key_mem[cur] != r.operand) begin
               prev = cur;
               cur  = link_mem[cur];
               steps++;
            end
            if (cur == 0 || key_mem[cur] != r.operand) begin
               res.status = slt_pkg::ST_NOT_FOUND;
            end else begin
               res.slot  = slt_pkg::SLOT_W'(cur);
               res.value = r.operand;
               // unlink only; the slot stays taken
               if (r.kind == slt_pkg::REQ_DELETE) begin
                  link_mem[prev] = link_mem[cur];
                  if (live_total > 0) live_total--;
               end
            end
         end
         default: begin
            if (live_total == 0 || cur == 0) begin
               res.status = slt_pkg::ST_EMPTY;
            end else begin
               target = (live_total + 1) / 2;
               for (int i = 1; i < target && i < SLOTS; i++) begin
                  nx = link_mem[cur];
                  if (nx == 0) break;
                  cur = nx;
               end
               res.slot  = slt_pkg::SLOT_W'(cur);
               res.value = key_mem[cur];
            end
         end
      endcase
      res.count = slt_pkg::SLOT_W'(live_total);
      return res;
   endfunction

   // append one request to the backlog and track inserted values
   function automatic void queue_op(slt_pkg::req_kind_type kind,
                                    logic signed [slt_pkg::VALUE_W-1:0] operand);
      table_req_type r;
      r.kind    = kind;
      r.operand = operand;
      if (kind == slt_pkg::REQ_INSERT) begin
         inserted_values.push_back(operand);
         inserts_issued++;
      end
      req_backlog.push_back(r);
   endfunction

   // operand drawn from earlier inserts, a narrow band, or anywhere
   function automatic logic signed [slt_pkg::VALUE_W-1:0] pick_operand(int hit_pct);
      logic signed [slt_pkg::VALUE_W-1:0] v;
      if (inserted_values.size() != 0 && $urandom_range(0, 99) < hit_pct)
         v = inserted_values[$urandom_range(0, inserted_values.size() - 1)];
      else if ($urandom_range(0, 1) == 0)
         v = $urandom_range(0, 31) - 16;
      else
         v = $urandom();
      return v;
   endfunction

   // mostly lookups and medians; inserts kept sparse so slots last the run
   function automatic void queue_random_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         queue_op(slt_pkg::REQ_INSERT, pick_operand(25));
      else if (roll < 13)
         queue_op(slt_pkg::REQ_DELETE, pick_operand(60));
      else if (roll < 60)
         queue_op(slt_pkg::REQ_SEARCH, pick_operand(70));
      else
         queue_op(slt_pkg::REQ_MEDIAN, $urandom());
   endfunction

   // hold the sender until all queued items are answered
   task automatic wait_for_idle();
      while (req_backlog.size() != 0 || req_chan.valid || rsp_due.size() != 0)
         @(posedge clock);
   endtask

   // request driver: present the next item, hold it until taken
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = req_backlog.pop_front();
            req_chan.valid    <= 1'b1;
            req_chan.req_type <= next_req.kind;
            req_chan.value    <= next_req.operand;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result receiver: random back-pressure
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // monitor: predict on request accept, check on result accept
   always @(posedge clock) begin
      if (reset) begin
         req_taken    = 1'b0;
         rsp_taken    = 1'b0;
         stall_cycles = 0;
      end else begin
         req_taken = req_chan.valid && req_chan.ready;
         rsp_taken = rsp_chan.valid && rsp_chan.ready;
         if (req_taken) begin
            seen_req.kind    = slt_pkg::req_kind_type'(req_chan.req_type);
            seen_req.operand = req_chan.value;
            rsp_due.push_back(table_apply(seen_req));
         end
         if (rsp_taken) begin
            if (rsp_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result: status=%0d slot=%0d value=%0d count=%0d",
                        $time, rsp_chan.status, rsp_chan.slot, rsp_chan.result_value,
                        rsp_chan.live_count);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_chan.status !== want.status || rsp_chan.slot !== want.slot ||
                   rsp_chan.result_value !== want.value ||
                   rsp_chan.live_count !== want.count) begin
                  fail_count++;
                  $display("%0t: mismatch: expected status=%0d slot=%0d value=%0d count=%0d",
                           $time, want.status, want.slot, want.value, want.count);
                  $display("%0t:           actual   status=%0d slot=%0d value=%0d count=%0d",
                           $time, rsp_chan.status, rsp_chan.slot, rsp_chan.result_value,
                           rsp_chan.live_count);
               end
            end
         end
         // watchdog on handshake activity
         if (req_taken || rsp_taken) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("[sorted_linked_list_table_core] ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.req_type = slt_pkg::REQ_INSERT;
      req_chan.value    = '0;
      rsp_chan.ready    = 1'b0;
      fail_count        = 0;
      slots_taken       = 0;
      live_total        = 0;
      link_mem[0]       = 0;
      inserts_issued    = 0;
      send_idle_pct     = 20;
      recv_idle_pct     = 81;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: median, search and delete all miss
      queue_op(slt_pkg::REQ_MEDIAN, 0);
      queue_op(slt_pkg::REQ_SEARCH, 7);
      queue_op(slt_pkg::REQ_DELETE, 7);
      // extremes, negatives and a duplicate that must land ahead of its twin
      queue_op(slt_pkg::REQ_INSERT, 0);
      queue_op(slt_pkg::REQ_INSERT, 32'sh8000_0000);
      queue_op(slt_pkg::REQ_INSERT, 32'sh7FFF_FFFF);
      queue_op(slt_pkg::REQ_INSERT, -1);
      queue_op(slt_pkg::REQ_INSERT, -9);
      queue_op(slt_pkg::REQ_INSERT, 0);
      queue_op(slt_pkg::REQ_SEARCH, 0);
      queue_op(slt_pkg::REQ_SEARCH, -9);
      queue_op(slt_pkg::REQ_SEARCH, 32'sh7FFF_FFFF);
      queue_op(slt_pkg::REQ_SEARCH, 5);
      queue_op(slt_pkg::REQ_MEDIAN, 0);
      // delete both copies, then miss; then drop head and tail
      queue_op(slt_pkg::REQ_DELETE, 0);
      queue_op(slt_pkg::REQ_DELETE, 0);
      queue_op(slt_pkg::REQ_DELETE, 0);
      queue_op(slt_pkg::REQ_DELETE, 32'sh8000_0000);
      queue_op(slt_pkg::REQ_DELETE, 32'sh7FFF_FFFF);
      queue_op(slt_pkg::REQ_MEDIAN, 0);
      queue_op(slt_pkg::REQ_INSERT, -5);
      queue_op(slt_pkg::REQ_MEDIAN, 0);
      queue_op(slt_pkg::REQ_SEARCH, 32'sh8000_0000);

      // three idle profiles, draining between them
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 81;
            recv_idle_pct = 20;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (RANDOM_PER_PHASE) queue_random_op();
         // make sure the table fills and a few inserts are refused
         if (phase == 2) begin
            while (inserts_issued < SLOTS + 2) queue_op(slt_pkg::REQ_INSERT, $urandom());
            repeat (4) queue_op(slt_pkg::REQ_MEDIAN, 0);
         end
         wait_for_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && rsp_due.size() == 0) begin
         $display("[sorted_linked_list_table_core] OK");
      end else begin
         $display("[sorted_linked_list_table_core] ERROR");
      end
      $finish;
   end

endmodule
